// ===== rtl/spl_pkg.sv =====
// shared types and constants for the sparse polynomial subtractor
package spl_pkg;

  localparam int unsigned SPL_MAX_TERMS = 16;
  localparam int unsigned EXP_W = 16;
  localparam int unsigned COEF_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_TERM  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MERGE,
    OP_INSERT,
    OP_ROTATE,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [EXP_W-1:0]  exp;
    logic [COEF_W-1:0] coef;
  } cell_data_t;

  typedef struct packed {
    cell_op_t          op;
    logic [EXP_W-1:0]  exp;
    logic [COEF_W-1:0] coef;
  } cell_ctl_t;

endpackage

// ===== rtl/spl_if.sv =====
// valid/ready channel interfaces for input and result words
interface spl_in_if import spl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [EXP_W-1:0]         term_exponent;
  logic signed [COEF_W-1:0] term_coefficient;

  modport source (output valid, cmd, term_exponent, term_coefficient, input ready);
  modport sink (input valid, cmd, term_exponent, term_coefficient, output ready);
endinterface

interface spl_out_if import spl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [EXP_W-1:0]         out_exponent;
  logic signed [COEF_W-1:0] out_coefficient;
  logic                     last;

  modport source (output valid, status, out_exponent, out_coefficient, last, input ready);
  modport sink (input valid, status, out_exponent, out_coefficient, last, output ready);
endinterface

// ===== rtl/spl_cell.sv =====
// one cell of the sorted term chain: holds a single term
module spl_cell import spl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl_i,
  input  cell_data_t left_i,
  input  logic       left_gt_i,
  input  cell_data_t right_i,
  input  cell_data_t head_i,
  output cell_data_t data_o,
  output logic       gt_o,
  output logic       match_o
);

  logic              valid_r;
  logic [EXP_W-1:0]  exp_r;
  logic [COEF_W-1:0] coef_r;
  cell_data_t        data_nxt;

  assign data_o  = '{valid: valid_r, exp: exp_r, coef: coef_r};
  assign gt_o    = valid_r && (exp_r > ctl_i.exp);
  assign match_o = valid_r && (exp_r == ctl_i.exp);

  always_comb begin
    data_nxt = data_o;
    case (ctl_i.op)
      OP_MERGE: begin
        if (match_o) data_nxt.coef = coef_r + ctl_i.coef;
      end
      OP_INSERT: begin
        // cells past the insertion point take their left neighbour
        if (!gt_o) begin
          if (left_gt_i) data_nxt = '{valid: 1'b1, exp: ctl_i.exp, coef: ctl_i.coef};
          else data_nxt = left_i;
        end
      end
      OP_ROTATE: begin
        // tail cell wraps round to the head
        if (valid_r) begin
          if (right_i.valid) data_nxt = right_i;
          else data_nxt = head_i;
        end
      end
      OP_CLEAR: data_nxt.valid = 1'b0;
      default: data_nxt = data_o;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= data_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    exp_r  <= data_nxt.exp;
    coef_r <= data_nxt.coef;
  end

endmodule

// ===== rtl/sparse_polynomial_subtractor.sv =====
// Sorted sparse polynomial term table built as a chain of MAX_TERMS cells, kept in
// strictly descending exponent order. Add, subtract and clear words each give one
// result word and can stream at one per cycle while the result side keeps up: every
// cell compares the incoming exponent at once and either merges, takes the new term
// or takes its left neighbour's term. Subtract adds the negated coefficient;
// coefficients wrap at 32 bits and zero terms stay. An insert into a full table is
// dropped with status full. A readout word gives one result for each of the n stored
// terms: the chain rotates one place per cycle while the result side keeps up, cell
// 0 feeding the output, and after n steps it is back in order. An empty table reads
// out as one result with status empty.
module sparse_polynomial_subtractor import spl_pkg::*; #(
  parameter int unsigned MAX_TERMS = SPL_MAX_TERMS
) (
  input  logic clk,
  input  logic rst_n,
  spl_in_if.sink    in_if,
  spl_out_if.source out_if
);

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [EXP_W-1:0]  out_exp_r;
  logic [COEF_W-1:0] out_coef_r;
  logic              out_last_r;

  logic              load_out;
  status_t           res_status;
  logic [EXP_W-1:0]  res_exp;
  logic [COEF_W-1:0] res_coef;
  logic              res_last;

  cell_ctl_t  ctl;
  cell_data_t cell_q [MAX_TERMS];
  logic [MAX_TERMS-1:0] gt_vec, match_vec, valid_vec;
  logic out_free, accept, any_match, full;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;
  assign any_match   = |match_vec;
  assign full        = (count_r == CW'(MAX_TERMS));

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    cell_data_t left_d, right_d;
    logic       left_gt;
    if (i == 0) begin : g_first
      assign left_d  = '0;
      assign left_gt = 1'b1;
    end else begin : g_mid
      assign left_d  = cell_q[i-1];
      assign left_gt = gt_vec[i-1];
    end
    if (i == MAX_TERMS - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    assign valid_vec[i] = cell_q[i].valid;

    spl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .left_i    (left_d),
      .left_gt_i (left_gt),
      .right_i   (right_d),
      .head_i    (cell_q[0]),
      .data_o    (cell_q[i]),
      .gt_o      (gt_vec[i]),
      .match_o   (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    load_out   = 1'b0;
    res_status = STAT_OK;
    res_exp    = '0;
    res_coef   = '0;
    res_last   = 1'b1;
    ctl.op     = OP_HOLD;
    ctl.exp    = in_if.term_exponent;
    ctl.coef   = (cmd_t'(in_if.cmd) == CMD_SUB) ? (COEF_W'(0) - in_if.term_coefficient)
                                                : in_if.term_coefficient;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_if.cmd))
            CMD_ADD, CMD_SUB: begin
              load_out = 1'b1;
              if (any_match) begin
                ctl.op = OP_MERGE;
              end else if (full) begin
                res_status = STAT_FULL;
              end else begin
                ctl.op    = OP_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                state_nxt = ST_READ;
                rem_nxt   = count_r;
              end
            end
            CMD_CLEAR: begin
              load_out  = 1'b1;
              ctl.op    = OP_CLEAR;
              count_nxt = '0;
            end
            default: load_out = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_status = STAT_TERM;
          res_exp    = cell_q[0].exp;
          res_coef   = cell_q[0].coef;
          res_last   = (rem_r == CW'(1));
          ctl.op     = OP_ROTATE;
          rem_nxt    = rem_r - CW'(1);
          if (rem_r == CW'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_exp_r    <= res_exp;
      out_coef_r   <= res_coef;
      out_last_r   <= res_last;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.out_exponent    = out_exp_r;
  assign out_if.out_coefficient = out_coef_r;
  assign out_if.last            = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count beyond table size");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with term count");

  a_read_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> rem_r != '0 && rem_r <= count_r)
    else $error("readout remaining count out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd_t'(in_if.cmd) == CMD_CLEAR |=> count_r == '0 && valid_vec == '0)
    else $error("clear left terms in the table");

endmodule

// ===== verif/tb_sparse_polynomial_subtractor.sv =====
// self-checking testbench for the sparse polynomial subtractor: term table model, driver, monitor
module tb_sparse_polynomial_subtractor import spl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 440;
  localparam int POOL_SIZE    = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int STUCK_LIMIT  = 2000;

  typedef struct {
    cmd_t              cmd;
    logic [EXP_W-1:0]  exponent;
    logic [COEF_W-1:0] coefficient;
    bit                hold_for_drain;
    int                n_results;
  } term_word_t;

  typedef struct {
    status_t           status;
    logic [EXP_W-1:0]  exponent;
    logic [COEF_W-1:0] coefficient;
    logic              last;
  } result_word_t;

  logic clk;
  logic rst_n;

  spl_in_if  in_ch ();
  spl_out_if out_ch ();

  sparse_polynomial_subtractor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predicted term table, ordered by descending exponent
  logic [EXP_W-1:0]  poly_exp [SPL_MAX_TERMS];
  logic [COEF_W-1:0] poly_coef[SPL_MAX_TERMS];
  int unsigned       poly_len;

  term_word_t        word_q[$];
  result_word_t      expected_q[$];
  logic [EXP_W-1:0]  exp_pool[POOL_SIZE];
  int                pool_used;

  int n_words;
  int n_reads;
  int n_merges;
  int n_drops;
  int n_errors;
  int words_taken;
  int results_owed;
  int results_seen;
  int stuck_cycles;
  int driven_results;

  function automatic status_t merge_into_poly(logic [EXP_W-1:0] e, logic [COEF_W-1:0] c);
    int unsigned pos;
    pos = 0;
    while (pos < poly_len && poly_exp[pos] > e) pos++;
    if (pos < poly_len && poly_exp[pos] == e) begin
      poly_coef[pos] += c;
      n_merges++;
      return STAT_OK;
    end
    if (poly_len >= SPL_MAX_TERMS) begin
      n_drops++;
      return STAT_FULL;
    end
    for (int unsigned i = poly_len; i > pos; i--) begin
      poly_exp[i]  = poly_exp[i-1];
      poly_coef[i] = poly_coef[i-1];
    end
    poly_exp[pos]  = e;
    poly_coef[pos] = c;
    poly_len++;
    return STAT_OK;
  endfunction

  // runs the table model on one word and queues the word with its results
  task automatic queue_term_word(cmd_t cmd, logic [EXP_W-1:0] e, logic [COEF_W-1:0] c,
                                 bit hold);
    result_word_t r;
    term_word_t   w;
    int           n_res;
    n_res         = 1;
    r.status      = STAT_OK;
    r.exponent    = '0;
    r.coefficient = '0;
    r.last        = 1'b1;
    case (cmd)
      CMD_ADD: r.status = merge_into_poly(e, c);
      CMD_SUB: r.status = merge_into_poly(e, -c);
      CMD_READ: begin
        n_reads++;
        if (poly_len == 0) r.status = STAT_EMPTY;
      end
      default: poly_len = 0;
    endcase
    if (cmd == CMD_READ && poly_len != 0) begin
      n_res = int'(poly_len);
      for (int unsigned i = 0; i < poly_len; i++) begin
        r.status      = STAT_TERM;
        r.exponent    = poly_exp[i];
        r.coefficient = poly_coef[i];
        r.last        = (i + 1 == poly_len);
        expected_q.push_back(r);
      end
    end else begin
      expected_q.push_back(r);
    end
    w.cmd            = cmd;
    w.exponent       = e;
    w.coefficient    = c;
    w.hold_for_drain = hold;
    w.n_results      = n_res;
    word_q.push_back(w);
    n_words++;
  endtask

  function automatic logic [EXP_W-1:0] pick_exponent();
    if ($urandom_range(0, 3) == 0) return EXP_W'($urandom);
    return exp_pool[$urandom_range(0, pool_used - 1)];
  endfunction

  function automatic logic [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // the first quarter of every hundred words runs back to back
  function automatic int draw_wait(int count);
    if (count % 100 < 25) return 0;
    return $urandom_range(0, 4);
  endfunction

  initial begin
    clk              = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_ADD;
    in_ch.term_exponent    = '0;
    in_ch.term_coefficient = '0;
    out_ch.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  // owed results: count of expectations belonging to words already handed over
  always @(posedge clk) begin : word_driver
    term_word_t w;
    int         gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap = 0;
      driven_results = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        words_taken++;
        results_owed += driven_results;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap != 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (word_q.size() != 0 &&
                     !(word_q[0].hold_for_drain && results_seen != results_owed)) begin
          w = word_q.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.cmd              <= w.cmd;
          in_ch.term_exponent    <= w.exponent;
          in_ch.term_coefficient <= w.coefficient;
          driven_results = w.n_results;
          gap = draw_wait(words_taken);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_word_t want;
    int           stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: status %0d exponent %h coefficient %h",
               out_ch.status, out_ch.out_exponent, out_ch.out_coefficient);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          n_errors++;
        end
        if (out_ch.out_exponent !== want.exponent) begin
          $error("out_exponent: expected %h, got %h", want.exponent, out_ch.out_exponent);
          n_errors++;
        end
        if (out_ch.out_coefficient !== want.coefficient) begin
          $error("out_coefficient: expected %h, got %h", want.coefficient,
                 out_ch.out_coefficient);
          n_errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          n_errors++;
        end
      end
      results_seen++;
      stall = draw_wait(results_seen + 50);
      if (stall != 0) out_ch.ready <= 1'b0;
    end else if (!out_ch.ready) begin
      if (stall <= 1) begin
        out_ch.ready <= 1'b1;
        stall = 0;
      end else begin
        stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("sparse_polynomial_subtractor test failed");
      $finish;
    end
  end

  initial begin
    int n_random;
    int n_minuend;
    int n_subtrahend;
    rst_n        = 1'b0;
    poly_len     = 0;
    n_words      = 0;
    n_reads      = 0;
    n_merges     = 0;
    n_drops      = 0;
    n_errors     = 0;
    words_taken  = 0;
    results_seen = 0;
    results_owed = 0;
    stuck_cycles = 0;
    pool_used    = 1;
    exp_pool[0]  = '0;

    // readout and clear of an empty table
    queue_term_word(CMD_READ, 16'h0000, 32'h0000_0000, 1'b0);
    queue_term_word(CMD_CLEAR, 16'hffff, 32'hffff_ffff, 1'b0);
    // extremes of exponent and coefficient, negating the most negative value
    queue_term_word(CMD_ADD, 16'h0000, 32'h7fff_ffff, 1'b0);
    queue_term_word(CMD_ADD, 16'hffff, 32'h8000_0000, 1'b0);
    queue_term_word(CMD_SUB, 16'h8000, 32'h8000_0000, 1'b0);
    queue_term_word(CMD_SUB, 16'h0005, 32'h0000_0001, 1'b0);
    // coefficient wraps over the top
    queue_term_word(CMD_ADD, 16'h0000, 32'h0000_0001, 1'b0);
    // cancels to a zero term, which stays
    queue_term_word(CMD_SUB, 16'hffff, 32'h8000_0000, 1'b0);
    queue_term_word(CMD_READ, 16'h1234, 32'h5678_9abc, 1'b0);
    for (int i = 0; i < 12; i++)
      queue_term_word(CMD_ADD, 16'h1000 + 16'(3 * i), $urandom, 1'b0);
    // full table: new exponents dropped, existing one still merges
    queue_term_word(CMD_ADD, 16'h0001, 32'h0000_0007, 1'b0);
    queue_term_word(CMD_ADD, 16'h8000, 32'h0000_0003, 1'b0);
    queue_term_word(CMD_SUB, 16'h7fff, 32'h0000_0009, 1'b0);
    queue_term_word(CMD_READ, 16'h0000, 32'h0000_0000, 1'b1);
    queue_term_word(CMD_CLEAR, 16'h0000, 32'h0000_0000, 1'b0);
    queue_term_word(CMD_READ, 16'h0000, 32'h0000_0000, 1'b0);

    // random part: mostly clear, minuend adds, subtrahend subtracts, readout
    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_term_word(cmd_t'(2'($urandom_range(0, 3))), EXP_W'($urandom), $urandom,
                        1'b0);
        n_random++;
      end else begin
        pool_used = $urandom_range(2, POOL_SIZE);
        for (int k = 0; k < POOL_SIZE; k++) begin
          case ($urandom_range(0, 5))
            0: exp_pool[k] = 16'h0000;
            1: exp_pool[k] = 16'hffff;
            2, 3: exp_pool[k] = EXP_W'($urandom_range(0, 31));
            default: exp_pool[k] = EXP_W'($urandom);
          endcase
        end
        n_minuend    = $urandom_range(0, 12);
        n_subtrahend = $urandom_range(0, 12);
        queue_term_word(CMD_CLEAR, EXP_W'($urandom), $urandom, $urandom_range(0, 7) == 0);
        for (int k = 0; k < n_minuend; k++)
          queue_term_word(CMD_ADD, pick_exponent(), pick_coefficient(), 1'b0);
        for (int k = 0; k < n_subtrahend; k++)
          queue_term_word(CMD_SUB, pick_exponent(), pick_coefficient(), 1'b0);
        queue_term_word(CMD_READ, EXP_W'($urandom), $urandom, 1'b0);
        n_random += 2 + n_minuend + n_subtrahend;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d readouts, %0d merges into stored terms",
             n_words, n_reads, n_merges);
    $display("%0d drops on a full table, %0d result words checked, %0d mismatches",
             n_drops, results_seen, n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("sparse_polynomial_subtractor test passed");
    end else begin
      $display("sparse_polynomial_subtractor test failed");
    end
    $finish;
  end

endmodule
